// ===== hw/rtl/mau_pkg.sv =====
package mau_pkg;

  // Width of the two signed operands of an item.
  localparam int WordBits = 32;
  // Width of the modulus and of every residue.
  localparam int ModBits  = 31;
  // Signed working width of the shared subtractors: covers 3 * modulus and
  // the Bezout coefficients with their alignment shifts.
  localparam int SumBits  = ModBits + 3;
  // Step counter: counts operand bits, multiplier bits and divisor alignment shifts.
  localparam int CntBits  = $clog2(WordBits + 1);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } mau_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED,
    ST_FIX,
    ST_OP,
    ST_ALIGN,
    ST_DIV,
    ST_SWAP,
    ST_INV,
    ST_MUL,
    ST_DONE
  } mau_state_e;

  typedef struct packed {
    mau_op_e                     opcode;
    logic signed [WordBits-1:0]  operand_a;
    logic signed [WordBits-1:0]  operand_b;
  } mau_in_t;

  typedef struct packed {
    logic [ModBits-1:0] residue;
    logic               no_inverse;
  } mau_out_t;

endpackage

// ===== hw/rtl/mau_core.sv =====
module mau_core import mau_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  mau_in_t            in_i,
  input  logic [ModBits-1:0] modulus_i,
  input  logic               res_take_i,
  output logic               idle_o,
  output logic               done_o,
  output mau_out_t           res_o
);

  mau_state_e state_q, state_d;

  logic                      phase_q, phase_d;
  logic                      neg_q, neg_d;
  mau_op_e                   op_q, op_d;
  logic [WordBits-1:0]       opb_q, opb_d;
  logic [WordBits-1:0]       mag_q, mag_d;
  logic [ModBits-1:0]        mod_q, mod_d;
  logic [ModBits-1:0]        rem_q, rem_d;
  logic [CntBits-1:0]        cnt_q, cnt_d;
  logic [ModBits-1:0]        ra_q, ra_d;
  logic [ModBits-1:0]        rb_q, rb_d;
  logic [ModBits-1:0]        r0_q, r0_d;
  logic [ModBits-1:0]        r1_q, r1_d;
  logic [ModBits+1:0]        dv_q, dv_d;
  logic signed [SumBits-1:0] t0_q, t0_d;
  logic signed [SumBits-1:0] t1_q, t1_d;
  logic signed [SumBits-1:0] s_q, s_d;
  logic [ModBits-1:0]        mb_q, mb_d;
  logic [ModBits-1:0]        acc_q, acc_d;
  logic                      flag_q, flag_d;

  // Shared subtractors.
  logic signed [SumBits-1:0] main_x, main_y, main_diff;
  logic signed [SumBits-1:0] aux_x, aux_y, aux_diff;

  logic [WordBits-1:0] a_raw, a_mag, b_mag;
  logic [ModBits:0]    red_shift;
  logic [ModBits:0]    sum_ab;
  logic [ModBits+1:0]  mul_sum;
  logic [ModBits-1:0]  red_val;

  assign a_raw     = in_i.operand_a;
  assign a_mag     = a_raw[WordBits-1] ? (~a_raw + WordBits'(1)) : a_raw;
  assign b_mag     = opb_q[WordBits-1] ? (~opb_q + WordBits'(1)) : opb_q;
  assign red_shift = {rem_q, mag_q[WordBits-1]};
  assign sum_ab    = {1'b0, ra_q} + {1'b0, rb_q};
  assign mul_sum   = {1'b0, acc_q, 1'b0} + (mb_q[ModBits-1] ? {2'b00, ra_q} : '0);

  // Operand selection for the shared subtractors.
  always_comb begin
    main_x = '0;
    main_y = '0;
    aux_x  = '0;
    aux_y  = '0;
    unique case (state_q)
      ST_RED: begin
        main_x = SumBits'(red_shift);
        main_y = SumBits'(mod_q);
      end
      ST_FIX: begin
        main_x = SumBits'(mod_q);
        main_y = SumBits'(rem_q);
      end
      ST_OP: begin
        if (op_q == OP_ADD) begin
          main_x = SumBits'(sum_ab);
          main_y = SumBits'(mod_q);
        end else begin
          main_x = SumBits'(ra_q);
          main_y = SumBits'(rb_q);
        end
      end
      ST_ALIGN: begin
        main_x = SumBits'(r0_q);
        main_y = SumBits'({dv_q, 1'b0});
      end
      ST_DIV: begin
        main_x = SumBits'(r0_q);
        main_y = SumBits'(dv_q);
        aux_x  = t0_q;
        aux_y  = s_q;
      end
      ST_INV: begin
        main_x = t0_q;
        main_y = -SumBits'(mod_q);
      end
      ST_MUL: begin
        main_x = SumBits'(mul_sum);
        main_y = SumBits'(mod_q);
        aux_x  = SumBits'(mul_sum);
        aux_y  = SumBits'({mod_q, 1'b0});
      end
      default: begin
      end
    endcase
  end

  assign main_diff = main_x - main_y;
  assign aux_diff  = aux_x - aux_y;

  // A negative operand with a nonzero remainder folds to modulus minus remainder.
  assign red_val = (neg_q && (rem_q != '0)) ? main_diff[ModBits-1:0] : rem_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start_i) state_d = ST_RED;
      ST_RED:   if (cnt_q == CntBits'(1)) state_d = ST_FIX;
      ST_FIX:   state_d = phase_q ? ST_OP : ST_RED;
      ST_OP: begin
        unique case (op_q)
          OP_MUL:  state_d = ST_MUL;
          OP_DIV:  state_d = (rb_q == '0) ? ST_INV : ST_ALIGN;
          default: state_d = ST_DONE;
        endcase
      end
      ST_ALIGN: if (main_diff[SumBits-1]) state_d = ST_DIV;
      ST_DIV:   if (cnt_q == '0) state_d = ST_SWAP;
      ST_SWAP:  state_d = (r0_q == '0) ? ST_INV : ST_ALIGN;
      ST_INV:   state_d = (r0_q != ModBits'(1)) ? ST_DONE : ST_MUL;
      ST_MUL:   if (cnt_q == CntBits'(1)) state_d = ST_DONE;
      ST_DONE:  if (res_take_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath register updates.
  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    op_d    = op_q;
    opb_d   = opb_q;
    mag_d   = mag_q;
    mod_d   = mod_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    ra_d    = ra_q;
    rb_d    = rb_q;
    r0_d    = r0_q;
    r1_d    = r1_q;
    dv_d    = dv_q;
    t0_d    = t0_q;
    t1_d    = t1_q;
    s_d     = s_q;
    mb_d    = mb_q;
    acc_d   = acc_q;
    flag_d  = flag_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          mod_d   = (modulus_i == '0) ? ModBits'(1) : modulus_i;
          op_d    = in_i.opcode;
          opb_d   = in_i.operand_b;
          neg_d   = a_raw[WordBits-1];
          mag_d   = a_mag;
          rem_d   = '0;
          cnt_d   = CntBits'(WordBits);
          phase_d = 1'b0;
        end
      end
      ST_RED: begin
        rem_d = main_diff[SumBits-1] ? red_shift[ModBits-1:0] : main_diff[ModBits-1:0];
        mag_d = mag_q << 1;
        cnt_d = cnt_q - CntBits'(1);
      end
      ST_FIX: begin
        if (!phase_q) begin
          ra_d    = red_val;
          phase_d = 1'b1;
          neg_d   = opb_q[WordBits-1];
          mag_d   = b_mag;
          rem_d   = '0;
          cnt_d   = CntBits'(WordBits);
        end else begin
          rb_d = red_val;
        end
      end
      ST_OP: begin
        flag_d = 1'b0;
        unique case (op_q)
          OP_ADD: begin
            acc_d = main_diff[SumBits-1] ? sum_ab[ModBits-1:0] : main_diff[ModBits-1:0];
          end
          OP_SUB: begin
            // Wraps in the residue width, so a negative difference lands on a - b + m.
            acc_d = main_diff[SumBits-1] ? (main_diff[ModBits-1:0] + mod_q)
                                         : main_diff[ModBits-1:0];
          end
          OP_MUL: begin
            acc_d = '0;
            mb_d  = rb_q;
            cnt_d = CntBits'(ModBits);
          end
          default: begin
            r0_d  = mod_q;
            r1_d  = rb_q;
            t0_d  = '0;
            t1_d  = SumBits'(1);
            dv_d  = (ModBits + 2)'(rb_q);
            s_d   = SumBits'(1);
            cnt_d = '0;
          end
        endcase
      end
      ST_ALIGN: begin
        if (!main_diff[SumBits-1]) begin
          dv_d  = dv_q << 1;
          s_d   = s_q <<< 1;
          cnt_d = cnt_q + CntBits'(1);
        end
      end
      ST_DIV: begin
        if (!main_diff[SumBits-1]) begin
          r0_d = main_diff[ModBits-1:0];
          t0_d = aux_diff;
        end
        dv_d = dv_q >> 1;
        s_d  = s_q >>> 1;
        if (cnt_q != '0) cnt_d = cnt_q - CntBits'(1);
      end
      ST_SWAP: begin
        r0_d  = r1_q;
        r1_d  = r0_q;
        t0_d  = t1_q;
        t1_d  = t0_q;
        dv_d  = (ModBits + 2)'(r0_q);
        s_d   = t0_q;
        cnt_d = '0;
      end
      ST_INV: begin
        acc_d = '0;
        if (r0_q != ModBits'(1)) begin
          flag_d = 1'b1;
        end else begin
          mb_d  = t0_q[SumBits-1] ? main_diff[ModBits-1:0] : t0_q[ModBits-1:0];
          cnt_d = CntBits'(ModBits);
        end
      end
      ST_MUL: begin
        if (!aux_diff[SumBits-1]) begin
          acc_d = aux_diff[ModBits-1:0];
        end else if (!main_diff[SumBits-1]) begin
          acc_d = main_diff[ModBits-1:0];
        end else begin
          acc_d = mul_sum[ModBits-1:0];
        end
        mb_d  = mb_q << 1;
        cnt_d = cnt_q - CntBits'(1);
      end
      default: begin
      end
    endcase
  end

  // Outputs.
  always_comb begin
    idle_o            = (state_q == ST_IDLE);
    done_o            = (state_q == ST_DONE);
    res_o.residue     = acc_q;
    res_o.no_inverse  = flag_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q <= phase_d;
    neg_q   <= neg_d;
    op_q    <= op_d;
    opb_q   <= opb_d;
    mag_q   <= mag_d;
    mod_q   <= mod_d;
    rem_q   <= rem_d;
    cnt_q   <= cnt_d;
    ra_q    <= ra_d;
    rb_q    <= rb_d;
    r0_q    <= r0_d;
    r1_q    <= r1_d;
    dv_q    <= dv_d;
    t0_q    <= t0_d;
    t1_q    <= t1_d;
    s_q     <= s_d;
    mb_q    <= mb_d;
    acc_q   <= acc_d;
    flag_q  <= flag_d;
  end

  // A finished residue is always below the modulus.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (acc_q < mod_q))
    else $error("residue not reduced below the modulus");

  // The missing-inverse flag comes with a zero residue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && flag_q) |-> (acc_q == '0))
    else $error("nonzero residue with missing inverse");

  // Only a divide can raise the missing-inverse flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && flag_q) |-> (op_q == OP_DIV))
    else $error("missing-inverse flag on a non-divide item");

  // The Euclid remainders stay ordered while a quotient is being formed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ALIGN) |-> (r1_q <= r0_q))
    else $error("Euclid remainders out of order");

endmodule

// ===== hw/rtl/modular_arithmetic_unit_top.sv =====
// Channel  Signals                                  Direction  Payload
// -------  ---------------------------------------  ---------  ---------------------------
// in       in_valid_i / in_ready_o / in_data_i       input      opcode, operand_a, operand_b
// out      out_valid_o / out_ready_i / out_data_o    output     residue, no_inverse
// cfg      cfg_we_i / cfg_data_i                     input      modulus (31 bits)
//
// One item at a time. Both operands are reduced one bit per cycle; add and subtract then
// finish with a modular add or subtract, and multiply adds a shift-and-add pass over the
// multiplier bits. Divide runs extended Euclid on the shared subtractors before the final
// multiply. Reset is asynchronous and active low; the modulus resets to 1. A finished item
// waits in the output register, so the core can take the next one meanwhile.
module modular_arithmetic_unit_top import mau_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mau_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mau_out_t           out_data_o,
  input  logic               cfg_we_i,
  input  logic [ModBits-1:0] cfg_data_i
);

  logic [ModBits-1:0] modulus_q;
  logic               out_valid_q;
  mau_out_t           out_data_q;

  logic     core_idle;
  logic     core_done;
  logic     core_take;
  logic     start;
  mau_out_t core_res;

  // The core takes an item only when its sequencer is back in idle.
  assign in_ready_o = core_idle;
  assign start      = in_valid_i && core_idle;

  // The output register frees the core as soon as it can hold the result.
  assign core_take  = core_done && (!out_valid_q || out_ready_i);

  mau_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .in_i       (in_data_i),
    .modulus_i  (modulus_q),
    .res_take_i (core_take),
    .idle_o     (core_idle),
    .done_o     (core_done),
    .res_o      (core_res)
  );

  // Modulus register; the user must write it only while no item is in flight, the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= ModBits'(1);
    end else if (cfg_we_i) begin
      modulus_q <= cfg_data_i;
    end
  end

  // Output stage: holds a result until the consumer takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_take) begin
      out_data_q <= core_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
